// ----- rtl/core/particle_pool_update_top_assert.svh -----
// Assertion macros for the particle pool update block.
// Used by particle_pool_update_top; expects clk and rst_n in scope.
`ifndef PARTICLE_POOL_UPDATE_TOP_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("particle pool check failed");
`define PPU_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("particle pool forbidden condition");
`else
`define PPU_ASSERT(lbl, prop)
`define PPU_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/core/ppu_pkg.sv -----
// Types, constants and emit tables for the particle pool update block.
// No dependencies.
`timescale 1ns / 1ps
package ppu_pkg;

    localparam logic [16:0] LIFE_ONE     = 17'd65536;
    localparam logic [15:0] SIZE_RESET   = 16'd13107;
    localparam logic [15:0] SEVEN_TENTHS = 16'd45875;
    localparam logic [6:0]  RAND_MAX     = 7'd99;

    localparam logic       CMD_EMIT = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_EMIT  = 2'd0;
    localparam logic [1:0] KIND_LIVE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic [16:0]        life;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vz;
        logic [15:0]        size;
    } entry_t;

    typedef struct packed {
        logic        cmd;
        logic        active;
        logic        found;
        logic [15:0] dt;
        logic [15:0] dec;
    } ctl_t;

    typedef logic signed [23:0] vel_tab_t [100];
    typedef logic [15:0] size_tab_t [100];

    function automatic vel_tab_t build_side();
        vel_tab_t t;
        int       num;
        for (int r = 0; r < 100; r++)
        begin
            num = (r - 50) * 458752;
            if (num >= 0)
                t[r] = 24'((num + 500) / 1000);
            else
                t[r] = 24'(-((-num + 500) / 1000));
        end
        return t;
    endfunction

    function automatic vel_tab_t build_up();
        vel_tab_t t;
        for (int r = 0; r < 100; r++)
            t[r] = 24'(98304 + (r * 65536 + 50) / 100);
        return t;
    endfunction

    function automatic size_tab_t build_size();
        size_tab_t t;
        for (int r = 0; r < 100; r++)
            t[r] = 16'(((60 + r) * 65536 + 200) / 400);
        return t;
    endfunction

    localparam vel_tab_t  SIDE_TAB = build_side();
    localparam vel_tab_t  UP_TAB   = build_up();
    localparam size_tab_t SIZE_TAB = build_size();

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607)
            return 24'sd8388607;
        else if (v < -28'sd8388608)
            return -24'sd8388608;
        else
            return v[23:0];
    endfunction

    function automatic logic signed [24:0] mul_dt(input logic signed [23:0] v,
                                                  input logic [15:0] dt);
        logic signed [40:0] p;
        p = 41'(v) * 41'($signed({1'b0, dt}));
        p = p + 41'sd32768;
        return p[40:16];
    endfunction

endpackage

// ----- rtl/core/ppu_cell.sv -----
// One pool slot of the particle ring; shifts toward slot 0 on each step.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  ppu_pkg::entry_t d,
    output ppu_pkg::entry_t q
);
    import ppu_pkg::*;

    entry_t ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '{size: SIZE_RESET, default: '0};
        end
        else if (shift)
        begin
            ent_reg <= d;
        end
    end

    assign q = ent_reg;
endmodule

// ----- rtl/core/ppu_unit.sv -----
// Update unit at the head of the ring: emit fill or Euler tick of one slot.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_unit (
    input  ppu_pkg::ctl_t   ctl,
    input  ppu_pkg::entry_t head,
    input  ppu_pkg::entry_t emit_ent,
    output ppu_pkg::entry_t nxt,
    output logic            take,
    output logic            live
);
    import ppu_pkg::*;

    logic [16:0] new_life;
    entry_t      upd;

    always_comb
    begin
        new_life = (head.life > {1'b0, ctl.dt}) ? head.life - {1'b0, ctl.dt} : 17'd0;
        upd      = head;
        upd.life = new_life;
        if (new_life != 17'd0)
        begin
            upd.px = sat24(28'(head.px) + 28'(mul_dt(head.vx, ctl.dt)));
            upd.py = sat24(28'(head.py) + 28'(mul_dt(head.vy, ctl.dt)));
            upd.pz = sat24(28'(head.pz) + 28'(mul_dt(head.vz, ctl.dt)));
            upd.vy = sat24(28'(head.vy) - 28'($signed({1'b0, ctl.dec})));
        end
    end

    always_comb
    begin
        take = 1'b0;
        live = 1'b0;
        nxt  = head;
        if (ctl.active)
        begin
            if (ctl.cmd == CMD_EMIT)
            begin
                if (!ctl.found && head.life == 17'd0)
                begin
                    take = 1'b1;
                    nxt  = emit_ent;
                end
            end
            else if (head.life != 17'd0)
            begin
                nxt  = upd;
                live = (new_life != 17'd0);
            end
        end
    end
endmodule

// ----- rtl/core/particle_pool_update_top.sv -----
// Particle pool update block: ring of slot cells with one shared update unit.
// Depends on ppu_pkg, ppu_cell, ppu_unit and particle_pool_update_top_assert.svh.
//
// Every word (emit or tick) rotates the whole ring of MAX_PARTICLES slots once
// through the update unit, one slot per cycle while no pause holds it; tick
// steps pause while the output register is full. A new word is accepted only
// in idle, once the last one has finished. Emit answers with one word; a tick
// answers with one word per live slot in slot order (tlast on the final one),
// or one empty-frame word. Write particles_in_use only while idle.
`timescale 1ns / 1ps
module particle_pool_update_top #(
    parameter int MAX_PARTICLES = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [5:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, rand_x, rand_z, rand_up, rand_size, delta_time
    input  logic [119:0] s_tdata,
    // cmd
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot_index, accepted, out_x, out_y, out_z, out_size, out_alpha
    output logic [111:0] m_tdata,
    // kind
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    import ppu_pkg::*;

    localparam int CW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic [4:0]         slot;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [15:0]        size;
        logic [16:0]        alpha;
    } res_t;

    state_t        state_reg, state_next;
    logic [5:0]    cfg_reg;
    logic [6:0]    n_reg;
    logic [CW-1:0] cnt_reg;
    logic          cmd_reg, found_reg, pend_valid_reg;
    logic [15:0]   dt_reg, dec_reg;
    entry_t        emit_reg;
    res_t          pend_reg;
    logic          out_valid_reg, out_last_reg, out_acc_reg;
    logic [1:0]    out_kind_reg;
    res_t          out_res_reg;

    entry_t        ring_q [MAX_PARTICLES];
    entry_t        ring_d [MAX_PARTICLES];
    entry_t        unit_nxt;
    ctl_t          ctl;
    logic          take, live, step, out_free, in_acc;
    logic [6:0]    rx, rz, ru, rs;
    logic [31:0]   dec_full;
    res_t          cur_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = (state_reg == S_RUN) && ((cmd_reg == CMD_EMIT) || out_free);

    assign rx = (s_tdata[78:72]  > RAND_MAX) ? RAND_MAX : s_tdata[78:72];
    assign rz = (s_tdata[85:79]  > RAND_MAX) ? RAND_MAX : s_tdata[85:79];
    assign ru = (s_tdata[92:86]  > RAND_MAX) ? RAND_MAX : s_tdata[92:86];
    assign rs = (s_tdata[99:93]  > RAND_MAX) ? RAND_MAX : s_tdata[99:93];
    assign dec_full = 32'(SEVEN_TENTHS) * 32'(s_tdata[115:100]) + 32'd32768;

    assign ctl.cmd    = cmd_reg;
    assign ctl.active = (7'(cnt_reg) < n_reg);
    assign ctl.found  = found_reg;
    assign ctl.dt     = dt_reg;
    assign ctl.dec    = dec_reg;

    genvar k;
    generate
        for (k = 0; k < MAX_PARTICLES; k++)
        begin : g_ring
            if (k == MAX_PARTICLES - 1)
            begin : g_tail
                assign ring_d[k] = unit_nxt;
            end
            else
            begin : g_link
                assign ring_d[k] = ring_q[k + 1];
            end
            ppu_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (step),
                .d     (ring_d[k]),
                .q     (ring_q[k])
            );
        end
    endgenerate

    ppu_unit u_unit (
        .ctl      (ctl),
        .head     (ring_q[0]),
        .emit_ent (emit_reg),
        .nxt      (unit_nxt),
        .take     (take),
        .live     (live)
    );

    assign cur_res.slot  = 5'(cnt_reg);
    assign cur_res.x     = unit_nxt.px;
    assign cur_res.y     = unit_nxt.py;
    assign cur_res.z     = unit_nxt.pz;
    assign cur_res.size  = unit_nxt.size;
    assign cur_res.alpha = unit_nxt.life;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_acc)
                    state_next = S_RUN;
            S_RUN:
                if (step && cnt_reg == CW'(MAX_PARTICLES - 1))
                    state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_reg        <= 6'd32;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;
            if (in_acc)
            begin
                cnt_reg        <= '0;
                found_reg      <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (step)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (take)
                    found_reg <= 1'b1;
                if (take || live)
                    pend_valid_reg <= 1'b1;
            end
            if ((step && live && pend_valid_reg) || (state_reg == S_DONE && out_free))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_DONE && out_free)
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg       <= s_tuser[0];
            n_reg         <= (7'(cfg_reg) > 7'(MAX_PARTICLES)) ? 7'(MAX_PARTICLES)
                                                               : 7'(cfg_reg);
            dt_reg        <= s_tdata[115:100];
            dec_reg       <= dec_full[31:16];
            emit_reg.life <= LIFE_ONE;
            emit_reg.px   <= s_tdata[23:0];
            emit_reg.py   <= s_tdata[47:24];
            emit_reg.pz   <= s_tdata[71:48];
            emit_reg.vx   <= SIDE_TAB[rx];
            emit_reg.vy   <= UP_TAB[ru];
            emit_reg.vz   <= SIDE_TAB[rz];
            emit_reg.size <= SIZE_TAB[rs];
        end
        if (step && (take || live))
            pend_reg <= cur_res;
        if (step && live && pend_valid_reg)
        begin
            out_res_reg  <= pend_reg;
            out_kind_reg <= KIND_LIVE;
            out_acc_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_last_reg <= 1'b1;
            if (cmd_reg == CMD_EMIT)
            begin
                out_kind_reg <= KIND_EMIT;
                out_acc_reg  <= pend_valid_reg;
                out_res_reg  <= pend_valid_reg ? pend_reg : '0;
            end
            else
            begin
                out_acc_reg  <= 1'b0;
                out_kind_reg <= pend_valid_reg ? KIND_LIVE : KIND_EMPTY;
                out_res_reg  <= pend_valid_reg ? pend_reg : '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_res_reg.alpha, out_res_reg.size, out_res_reg.z,
                       out_res_reg.y, out_res_reg.x, out_acc_reg, out_res_reg.slot};

`include "particle_pool_update_top_assert.svh"

    `PPU_ASSERT(a_state_onehot, $onehot(state_reg))
    `PPU_ASSERT(a_idle_no_pend, (state_reg == S_IDLE) |-> !pend_valid_reg)
    `PPU_NEVER(a_single_fill, step && found_reg && take)
    `PPU_ASSERT(a_run_count, (state_reg == S_RUN) |-> (7'(cnt_reg) < 7'(MAX_PARTICLES)))

endmodule
